### src/quadratic_root_solver_macros.svh
// assertion macros shared by the quadratic root solver rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/qrs_pkg.sv
// shared types and constants for the quadratic root solver
// no dependencies
package qrs_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_DEGEN    = 2'd3
    } root_kind_t;

endpackage

### src/qrs_front.sv
// front end: coefficient products, exact discriminant and root classification
// depends on qrs_pkg
module qrs_front
    import qrs_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [WORD_BITS-1:0] coef_a,
    input  logic signed [WORD_BITS-1:0] coef_b,
    input  logic signed [WORD_BITS-1:0] coef_c,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2*WORD_BITS:0]        out_disc,
    output root_kind_t                  out_kind,
    output logic signed [WORD_BITS-1:0] out_b,
    output logic [WORD_BITS-1:0]        out_amag,
    output logic                        out_aneg
);

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * W + 1;

    logic                 v1_reg, v2_reg;
    logic                 azero1_reg, sdiff1_reg, aneg1_reg, aneg2_reg;
    logic signed [W-1:0]  b1_reg, b2_reg;
    logic [W-1:0]         amag1_reg, amag2_reg;
    logic [2*W-1:0]       bb1_reg, ac1_reg;
    logic [DW-1:0]        disc2_reg;
    root_kind_t           kind2_reg;

    logic                 adv;
    logic [W-1:0]         am, bm, cm;
    logic [DW-1:0]        bb_ext, ac4;
    logic [DW-1:0]        disc_next;
    logic                 dneg;
    root_kind_t           kind_next;

    assign adv      = !v2_reg || out_ready;
    assign in_ready = adv;

    assign am = coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
    assign bm = coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
    assign cm = coef_c[W-1] ? W'(-coef_c) : W'(coef_c);

    // |a|*|c| is at most 2^(2W-2), so its top bit is always clear
    assign bb_ext = DW'(bb1_reg);
    assign ac4    = {ac1_reg[2*W-2:0], 2'b00};

    always_comb
    begin
        dneg = 1'b0;
        if (sdiff1_reg)
        begin
            disc_next = bb_ext + ac4;
        end
        else if (bb_ext >= ac4)
        begin
            disc_next = bb_ext - ac4;
        end
        else
        begin
            disc_next = ac4 - bb_ext;
            dneg      = 1'b1;
        end
        if (azero1_reg)
            kind_next = KIND_DEGEN;
        else if (disc_next == '0)
            kind_next = KIND_DOUBLE;
        else if (dneg)
            kind_next = KIND_COMPLEX;
        else
            kind_next = KIND_TWO_REAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            azero1_reg <= (coef_a == '0);
            sdiff1_reg <= coef_a[W-1] ^ coef_c[W-1];
            aneg1_reg  <= coef_a[W-1];
            b1_reg     <= coef_b;
            amag1_reg  <= am;
            bb1_reg    <= bm * bm;
            ac1_reg    <= am * cm;
            disc2_reg  <= disc_next;
            kind2_reg  <= kind_next;
            b2_reg     <= b1_reg;
            amag2_reg  <= amag1_reg;
            aneg2_reg  <= aneg1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_disc  = disc2_reg;
    assign out_kind  = kind2_reg;
    assign out_b     = b2_reg;
    assign out_amag  = amag2_reg;
    assign out_aneg  = aneg2_reg;

endmodule

### src/qrs_queue.sv
// short register queue between the front end and the root pipeline
// depends on qrs_pkg and the assertion macro header
`include "quadratic_root_solver_macros.svh"
module qrs_queue
    import qrs_pkg::*;
#(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] in_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 out_valid,
    output logic [DATA_BITS-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [AW-1:0]        wr_reg, rd_reg;
    logic [CW-1:0]        count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_data;
    end

    `QRS_ASSERT_NOW(a_no_overflow, push, !full, "queue push while full")
    `QRS_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "queue pop while empty")
    `QRS_ASSERT_NEXT(a_push_holds, push && !pop, count_reg != '0, "queue lost a pushed entry")

endmodule

### src/qrs_sqrt.sv
// pipelined integer square root, one root bit per stage, with a sideband
// depends on qrs_pkg
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int ROOT_BITS = WORD_BITS_DEF + 1,
    parameter int SB_BITS   = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [2*ROOT_BITS-1:0] in_rad,
    input  logic [SB_BITS-1:0]     in_sb,
    output logic                   out_valid,
    output logic [ROOT_BITS-1:0]   out_root,
    output logic [SB_BITS-1:0]     out_sb
);

    localparam int SW = ROOT_BITS;
    localparam int RW = 2 * SW;

    logic            vld_reg  [SW];
    logic [RW-1:0]   rad_reg  [SW];
    logic [SW+1:0]   rem_reg  [SW];
    logic [SW-1:0]   root_reg [SW];
    logic [SB_BITS-1:0] sb_reg [SW];

    logic            vld_in  [SW];
    logic [RW-1:0]   rad_in  [SW];
    logic [SW+1:0]   rem_in  [SW];
    logic [SW-1:0]   root_in [SW];
    logic [SB_BITS-1:0] sb_in [SW];

    for (genvar k = 0; k < SW; k++)
    begin : g_stage
        logic [SW+1:0] rem_sh, trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign vld_in[k]  = in_valid;
            assign rad_in[k]  = in_rad;
            assign rem_in[k]  = '0;
            assign root_in[k] = '0;
            assign sb_in[k]   = in_sb;
        end
        else
        begin : g_rest
            assign vld_in[k]  = vld_reg[k-1];
            assign rad_in[k]  = rad_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            assign sb_in[k]   = sb_reg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_sh = {rem_in[k][SW-1:0], rad_in[k][RW-1:RW-2]};
        assign trial  = {root_in[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_in[k][RW-3:0], 2'b00};
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {root_in[k][SW-2:0], ge};
                sb_reg[k]   <= sb_in[k];
            end
        end
    end

    assign out_valid = vld_reg[SW-1];
    assign out_root  = root_reg[SW-1];
    assign out_sb    = sb_reg[SW-1];

endmodule

### src/qrs_div_pair.sv
// two pipelined restoring dividers sharing one divisor, one quotient bit per stage
// depends on qrs_pkg
module qrs_div_pair
    import qrs_pkg::*;
#(
    parameter int NUM_BITS = 49,
    parameter int DEN_BITS = 33,
    parameter int SB_BITS  = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_BITS-1:0] in_num1,
    input  logic [NUM_BITS-1:0] in_num2,
    input  logic [DEN_BITS-1:0] in_den,
    input  logic [SB_BITS-1:0]  in_sb,
    output logic                out_valid,
    output logic [NUM_BITS-1:0] out_quo1,
    output logic [NUM_BITS-1:0] out_quo2,
    output logic [SB_BITS-1:0]  out_sb
);

    localparam int NB = NUM_BITS;
    localparam int DB = DEN_BITS;

    logic            vld_reg  [NB];
    logic [NB-1:0]   nq1_reg  [NB];
    logic [NB-1:0]   nq2_reg  [NB];
    logic [DB:0]     rem1_reg [NB];
    logic [DB:0]     rem2_reg [NB];
    logic [DB-1:0]   den_reg  [NB];
    logic [SB_BITS-1:0] sb_reg [NB];

    logic            vld_in  [NB];
    logic [NB-1:0]   nq1_in  [NB];
    logic [NB-1:0]   nq2_in  [NB];
    logic [DB:0]     rem1_in [NB];
    logic [DB:0]     rem2_in [NB];
    logic [DB-1:0]   den_in  [NB];
    logic [SB_BITS-1:0] sb_in [NB];

    for (genvar k = 0; k < NB; k++)
    begin : g_stage
        logic [DB:0] sh1, sh2, den_ext;
        logic        ge1, ge2;

        if (k == 0)
        begin : g_first
            assign vld_in[k]  = in_valid;
            assign nq1_in[k]  = in_num1;
            assign nq2_in[k]  = in_num2;
            assign rem1_in[k] = '0;
            assign rem2_in[k] = '0;
            assign den_in[k]  = in_den;
            assign sb_in[k]   = in_sb;
        end
        else
        begin : g_rest
            assign vld_in[k]  = vld_reg[k-1];
            assign nq1_in[k]  = nq1_reg[k-1];
            assign nq2_in[k]  = nq2_reg[k-1];
            assign rem1_in[k] = rem1_reg[k-1];
            assign rem2_in[k] = rem2_reg[k-1];
            assign den_in[k]  = den_reg[k-1];
            assign sb_in[k]   = sb_reg[k-1];
        end

        // numerator bits shift out the top while quotient bits shift in below
        assign den_ext = {1'b0, den_in[k]};
        assign sh1     = {rem1_in[k][DB-1:0], nq1_in[k][NB-1]};
        assign sh2     = {rem2_in[k][DB-1:0], nq2_in[k][NB-1]};
        assign ge1     = (sh1 >= den_ext);
        assign ge2     = (sh2 >= den_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq1_reg[k]  <= {nq1_in[k][NB-2:0], ge1};
                nq2_reg[k]  <= {nq2_in[k][NB-2:0], ge2};
                rem1_reg[k] <= ge1 ? sh1 - den_ext : sh1;
                rem2_reg[k] <= ge2 ? sh2 - den_ext : sh2;
                den_reg[k]  <= den_in[k];
                sb_reg[k]   <= sb_in[k];
            end
        end
    end

    assign out_valid = vld_reg[NB-1];
    assign out_quo1  = nq1_reg[NB-1];
    assign out_quo2  = nq2_reg[NB-1];
    assign out_sb    = sb_reg[NB-1];

endmodule

### src/quadratic_root_solver.sv
// Quadratic root solver, top level: roots of a*x^2 + b*x + c in signed fixed point.
// Slave channel s_*: one beat carries coef_a, coef_b, coef_c (WORD_BITS each,
// FRAC_BITS fraction bits). Master channel m_*: one beat per input beat, in order,
// carrying the root kind, the two result values and a saturation flag.
// A beat (Q16.16 at the defaults) passes through the front-end registers, the queue,
// WORD_BITS+1 square root stages, the numerator register, WORD_BITS+FRAC_BITS+1
// divider stages and the output register. Throughput is one beat per cycle while
// m_tready is high; the bit-per-stage square root and divider pipelines set the
// latency, not the rate.
// When m_tvalid is high and m_tready low the output register holds and the root
// pipeline freezes; the front end accepts until the four-entry queue is full and its
// output stage holds a beat, then drops s_tready. Reset (rst_n low, asynchronous)
// empties every stage and the queue; no beat is in flight afterwards, s_tready is high.
// depends on qrs_pkg, qrs_front, qrs_queue, qrs_sqrt, qrs_div_pair, macro header
`include "quadratic_root_solver_macros.svh"
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int IN_TDATA_BITS  = ((3 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_BITS = ((2 * WORD_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // coef_a, coef_b, coef_c, zero fill
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // first_value, second_value, zero fill
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    // root_kind, saturated
    output logic [2:0]                m_tuser
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W + 1;
    localparam int SW  = W + 1;
    localparam int QW  = W + 1 + F;
    localparam int SBW = 2 + W + W + 1;
    localparam int EW  = SBW + DW;

    localparam logic [QW-1:0] HALF   = QW'(1) << (W - 1);
    localparam logic [W-1:0]  MAXVAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINVAL = {1'b1, {(W-1){1'b0}}};

    logic en;

    // front end
    logic                f_valid, q_full;
    logic [DW-1:0]       f_disc;
    root_kind_t          f_kind;
    logic signed [W-1:0] f_b;
    logic [W-1:0]        f_amag;
    logic                f_aneg;

    qrs_front #(.WORD_BITS(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .coef_a    (s_tdata[W-1:0]),
        .coef_b    (s_tdata[2*W-1:W]),
        .coef_c    (s_tdata[3*W-1:2*W]),
        .out_valid (f_valid),
        .out_ready (!q_full),
        .out_disc  (f_disc),
        .out_kind  (f_kind),
        .out_b     (f_b),
        .out_amag  (f_amag),
        .out_aneg  (f_aneg)
    );

    // queue
    logic          q_valid;
    logic [EW-1:0] q_data;

    qrs_queue #(.DATA_BITS(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && !q_full),
        .in_data   ({f_kind, f_b, f_amag, f_aneg, f_disc}),
        .full      (q_full),
        .pop       (en && q_valid),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // square root of the discriminant magnitude
    logic           r_valid;
    logic [SW-1:0]  r_root;
    logic [SBW-1:0] r_sb;

    qrs_sqrt #(.ROOT_BITS(SW), .SB_BITS(SBW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_rad    ({1'b0, q_data[DW-1:0]}),
        .in_sb     (q_data[EW-1:DW]),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_sb    (r_sb)
    );

    // numerators, signs and divisor
    root_kind_t          r_kind;
    logic signed [W-1:0] r_b;
    logic [W-1:0]        r_amag;
    logic                r_aneg;
    logic signed [W+1:0] nb, sx, n1, n2;
    logic [W:0]          m1, m2;

    assign r_kind = root_kind_t'(r_sb[SBW-1:SBW-2]);
    assign r_b    = r_sb[SBW-3:W+1];
    assign r_amag = r_sb[W:1];
    assign r_aneg = r_sb[0];
    assign nb     = -((W+2)'(r_b));
    assign sx     = signed'({1'b0, r_root});

    always_comb
    begin
        case (r_kind)
            KIND_TWO_REAL:
            begin
                n1 = nb + sx;
                n2 = nb - sx;
            end
            KIND_COMPLEX:
            begin
                n1 = nb;
                n2 = sx;
            end
            default:
            begin
                n1 = nb;
                n2 = nb;
            end
        endcase
    end

    assign m1 = n1[W+1] ? (W+1)'(-n1) : n1[W:0];
    assign m2 = n2[W+1] ? (W+1)'(-n2) : n2[W:0];

    logic          n_valid_reg;
    logic [QW-1:0] num1_reg, num2_reg;
    logic [W:0]    den_reg;
    logic [3:0]    nsb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= {m1, {F{1'b0}}};
            num2_reg <= {m2, {F{1'b0}}};
            den_reg  <= {r_amag, 1'b0};
            nsb_reg  <= {r_kind, n1[W+1] ^ r_aneg, n2[W+1] ^ r_aneg};
        end
    end

    // dividers
    logic          d_valid;
    logic [QW-1:0] d_q1, d_q2;
    logic [3:0]    d_sb;

    qrs_div_pair #(.NUM_BITS(QW), .DEN_BITS(W + 1), .SB_BITS(4)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid_reg),
        .in_num1   (num1_reg),
        .in_num2   (num2_reg),
        .in_den    (den_reg),
        .in_sb     (nsb_reg),
        .out_valid (d_valid),
        .out_quo1  (d_q1),
        .out_quo2  (d_q2),
        .out_sb    (d_sb)
    );

    // clip, order and package the result
    root_kind_t   d_kind;
    logic         neg1, neg2, sat1, sat2;
    logic [W-1:0] v1, v2;
    logic [W-1:0] first_next, second_next;
    logic         sat_next;

    assign d_kind = root_kind_t'(d_sb[3:2]);
    assign neg1   = d_sb[1];
    assign neg2   = d_sb[0];
    assign sat1   = d_q1 > (neg1 ? HALF : HALF - 1'b1);
    assign sat2   = d_q2 > (neg2 ? HALF : HALF - 1'b1);
    assign v1     = sat1 ? (neg1 ? MINVAL : MAXVAL) : (neg1 ? -d_q1[W-1:0] : d_q1[W-1:0]);
    assign v2     = sat2 ? (neg2 ? MINVAL : MAXVAL) : (neg2 ? -d_q2[W-1:0] : d_q2[W-1:0]);

    always_comb
    begin
        case (d_kind)
            KIND_TWO_REAL:
            begin
                if ($signed(v1) < $signed(v2))
                begin
                    first_next  = v2;
                    second_next = v1;
                end
                else
                begin
                    first_next  = v1;
                    second_next = v2;
                end
                sat_next = sat1 | sat2;
            end
            KIND_DOUBLE:
            begin
                first_next  = v1;
                second_next = v1;
                sat_next    = sat1;
            end
            KIND_COMPLEX:
            begin
                first_next  = v1;
                second_next = v2;
                sat_next    = sat1 | sat2;
            end
            default:
            begin
                first_next  = '0;
                second_next = '0;
                sat_next    = 1'b0;
            end
        endcase
    end

    logic         m_valid_reg;
    root_kind_t   kind_reg;
    logic [W-1:0] first_reg, second_reg;
    logic         sat_reg;

    assign en = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg   <= d_kind;
            first_reg  <= first_next;
            second_reg <= second_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'({second_reg, first_reg});
    assign m_tuser  = {sat_reg, kind_reg};

    `QRS_ASSERT_NOW(a_degen_zero, m_valid_reg && kind_reg == KIND_DEGEN, first_reg == '0 && second_reg == '0 && !sat_reg, "degenerate beat with nonzero values")
    `QRS_ASSERT_NOW(a_real_order, m_valid_reg && kind_reg == KIND_TWO_REAL, $signed(first_reg) >= $signed(second_reg), "real roots out of order")
    `QRS_ASSERT_NOW(a_double_copy, m_valid_reg && kind_reg == KIND_DOUBLE, first_reg == second_reg, "double root values differ")

endmodule

### test/quadratic_root_solver_test.sv
// self-checking bench for quadratic_root_solver: random and directed coefficient beats,
// results predicted in-bench and compared in order; depends on qrs_pkg and the rtl
module quadratic_root_solver_test;
    import qrs_pkg::*;

    typedef struct {
        root_kind_t       kind;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic             sat;
    } roots_t;

    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    logic [95:0] coef_queue[$];
    roots_t      roots_due[$];
    int          errors;
    int          sent;
    int          cycles;
    int          quiet;
    int          hold_left;
    bit          held_once;

    quadratic_root_solver dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 clk = ~clk;

    // trunc(n * 2^16 / (2a)) clipped to 32 bits; bit 32 of the result is the clip flag
    function automatic logic [32:0] scaled_quotient(logic signed [127:0] n,
                                                    logic signed [127:0] a);
        logic [127:0] mag;
        logic [127:0] amag;
        logic [127:0] q;
        logic [127:0] lim;
        bit           neg;
        mag  = n < 0 ? -n : n;
        amag = a < 0 ? -a : a;
        neg  = (n < 0) != (a < 0);
        q    = (mag << 16) / (amag << 1);
        lim  = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim)
            return {1'b1, neg ? 32'h8000_0000 : 32'h7fff_ffff};
        return {1'b0, neg ? -q[31:0] : q[31:0]};
    endfunction

    function automatic roots_t solve_roots(logic [95:0] coefs);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] d;
        logic signed [127:0] dm;
        logic signed [127:0] s;
        logic signed [127:0] t;
        logic [32:0]         q1;
        logic [32:0]         q2;
        roots_t              r;
        a = $signed(coefs[31:0]);
        b = $signed(coefs[63:32]);
        c = $signed(coefs[95:64]);
        r.kind = KIND_DEGEN;
        r.first = 0;
        r.second = 0;
        r.sat = 0;
        if (a == 0)
            return r;
        d  = b * b - 4 * a * c;
        dm = d < 0 ? -d : d;
        s  = 0;
        for (int i = 40; i >= 0; i--)
        begin
            t = s | (128'sd1 << i);
            if (t * t <= dm)
                s = t;
        end
        if (d == 0)
        begin
            q1 = scaled_quotient(-b, a);
            r.kind = KIND_DOUBLE;
            r.first = q1[31:0];
            r.second = q1[31:0];
            r.sat = q1[32];
        end
        else if (d > 0)
        begin
            q1 = scaled_quotient(-b + s, a);
            q2 = scaled_quotient(-b - s, a);
            r.kind = KIND_TWO_REAL;
            r.sat = q1[32] | q2[32];
            if ($signed(q1[31:0]) < $signed(q2[31:0]))
            begin
                r.first = q2[31:0];
                r.second = q1[31:0];
            end
            else
            begin
                r.first = q1[31:0];
                r.second = q2[31:0];
            end
        end
        else
        begin
            q1 = scaled_quotient(-b, a);
            q2 = scaled_quotient(s, a);
            r.kind = KIND_COMPLEX;
            r.first = q1[31:0];
            r.second = q2[31:0];
            r.sat = q1[32] | q2[32];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] small_word();
        logic [31:0] v;
        v = $urandom_range(0, 20) << 16;
        v = v + $urandom_range(0, 65535);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [95:0] random_coefs();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] m;
        int          pick;
        pick = $urandom_range(0, 9);
        a = $urandom;
        b = $urandom;
        c = $urandom;
        if (pick < 4)
        begin
            a = small_word();
            b = small_word();
            c = small_word();
        end
        else if (pick == 4)
        begin
            // perfect square gives a double root
            m = $urandom_range(1, 32'h3fff_ffff);
            if ($urandom_range(0, 1))
                m = -m;
            a = m;
            c = m;
            b = m << 1;
        end
        else if (pick == 5)
            a = 0;
        else if (pick == 6)
            a = $urandom_range(1, 300) * ($urandom_range(0, 1) ? -1 : 1);
        return {c, b, a};
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit idle;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                roots_due.push_back(solve_roots(s_tdata));
                void'(coef_queue.pop_front());
                sent++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                idle = ($urandom_range(0, 99) < 19) && !(sent > 300 && sent < 600);
                // one pause until the pipeline has drained
                if (sent == 900 && roots_due.size() != 0)
                    idle = 1;
                if (coef_queue.size() != 0 && !idle)
                begin
                    s_tdata  <= coef_queue[0];
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        roots_t want;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (roots_due.size() == 0)
                    report_mismatch("unexpected beat", m_tdata, 64'h0);
                else
                begin
                    want = roots_due.pop_front();
                    if (m_tuser[1:0] !== want.kind)
                        report_mismatch("root_kind", m_tuser[1:0], want.kind);
                    if (m_tdata[31:0] !== want.first)
                        report_mismatch("first_value", m_tdata[31:0], want.first);
                    if (m_tdata[63:32] !== want.second)
                        report_mismatch("second_value", m_tdata[63:32], want.second);
                    if (m_tuser[2] !== want.sat)
                        report_mismatch("saturated", m_tuser[2], want.sat);
                end
            end
            // long hold-off so the input side backs up
            if (!held_once && sent >= 400)
            begin
                held_once = 1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(($urandom_range(0, 99) < 19) && !(cycles > 2500 && cycles < 3500));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        errors = 0;
        sent = 0;
        cycles = 0;
        quiet = 0;
        held_once = 0;
        // directed beats: {c, b, a}
        coef_queue.push_back({32'h0001_0000, 32'h0002_0000, 32'h0000_0000});
        coef_queue.push_back({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        coef_queue.push_back({32'h0001_0000, 32'h0002_0000, 32'h0001_0000});
        coef_queue.push_back({32'hfffe_0000, 32'h0000_0000, 32'h0002_0000});
        coef_queue.push_back({32'h0001_0000, 32'h0000_0000, 32'h0001_0000});
        coef_queue.push_back({32'h0001_0000, 32'h0000_0000, 32'hffff_0000});
        coef_queue.push_back({32'h0006_0000, 32'hfffb_0000, 32'h0001_0000});
        coef_queue.push_back({32'h0000_0000, 32'h7fff_ffff, 32'h0000_0001});
        coef_queue.push_back({32'h0000_0000, 32'h8000_0000, 32'h0000_0001});
        coef_queue.push_back({32'h7fff_ffff, 32'h0000_0000, 32'h0000_0001});
        coef_queue.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        coef_queue.push_back({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        coef_queue.push_back({32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff});
        coef_queue.push_back({32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000});
        coef_queue.push_back({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        coef_queue.push_back({32'h4000_0000, 32'h8000_0000, 32'h4000_0000});
        coef_queue.push_back({32'h0000_0001, 32'h0000_0002, 32'h0000_0001});
        coef_queue.push_back({32'hffff_ffff, 32'h0000_0000, 32'h0000_0001});
        coef_queue.push_back({32'h0000_0001, 32'h0000_0000, 32'hffff_ffff});
        for (int i = 0; i < 1700; i++)
            coef_queue.push_back(random_coefs());
        repeat (4) @(posedge clk);
        rst_n = 1;
        wait (coef_queue.size() == 0);
        wait (roots_due.size() == 0);
        repeat (120) @(posedge clk);
        if (errors == 0 && roots_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/qrs_pkg.sv
src/qrs_front.sv
src/qrs_queue.sv
src/qrs_sqrt.sv
src/qrs_div_pair.sv
src/quadratic_root_solver.sv
test/quadratic_root_solver_test.sv
